### sv/rwlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rwlt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int KEY_W             = 64;
    localparam int COUNT_W           = 15;
    localparam int KIND_W            = 2;
    localparam int STATUS_W          = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // request kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNLOCK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RCFULL = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_APPLY
    } t_state;

endpackage
`default_nettype wire

### sv/rwlt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rwlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/reader_writer_lock_table.sv
// A request scans the key entries in order until one holds its key; a new key scans them all
// (one key compare per cycle on the shared comparator, then one count fetch and one update),
// and a full table is answered at the end of the scan.
// One request at a time: busy drops in the cycle the result is strobed, and only then is a new one taken.
// A no-operation kind is answered the cycle after acceptance. Results cannot be stalled.
// Reset (synchronous, active low) clears all valid and held flags; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module reader_writer_lock_table #(
    parameter int TABLE_ENTRIES = rwlt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [rwlt_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [rwlt_pkg::KEY_W-1:0]     i_key,
    output logic                                o_strobe,
    output logic      [rwlt_pkg::STATUS_W-1:0]  o_status,
    output logic                                o_still_in_use,
    output logic      [rwlt_pkg::COUNT_W-1:0]   o_readers_now
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam int CW    = rwlt_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

    // control state
    rwlt_pkg::t_state            r_state, n_state;
    logic [TABLE_ENTRIES-1:0]    r_valid;
    logic [TABLE_ENTRIES-1:0]    r_wheld;
    logic [TABLE_ENTRIES-1:0]    r_rheld;

    // request and scan registers
    logic [rwlt_pkg::KIND_W-1:0] r_kind;
    logic [rwlt_pkg::KEY_W-1:0]  r_key;
    logic [CNT_W-1:0]            r_idx;      // next entry to read from the key RAM
    logic                        r_pend;     // a key read is in flight
    logic [IDX_W-1:0]            r_pidx;     // entry of the key read in flight
    logic                        r_free_ok;  // a free entry has been seen
    logic [IDX_W-1:0]            r_free_idx; // lowest free entry seen
    logic [IDX_W-1:0]            r_entry;    // entry chosen for the update
    logic                        r_hit;      // chosen entry already held this key

    // RAM ports
    logic [rwlt_pkg::KEY_W-1:0]  key_rd;
    logic [2*CW-1:0]             cnt_rd;
    logic [2*CW-1:0]             cnt_wr;
    logic                        apply_we;
    logic                        key_we;

    // scan decisions
    logic                        c_match;
    logic                        c_scan_end;
    logic                        c_accept;

    // update datapath
    logic [CW-1:0]               cur_wc, cur_rc, new_wc, new_rc;
    logic                        cur_wh, cur_rh, new_wh, new_rh;
    logic [rwlt_pkg::STATUS_W-1:0] c_status;
    logic                        c_used;

    // result load
    logic                        c_out_load;
    logic [rwlt_pkg::STATUS_W-1:0] c_out_status;
    logic                        c_out_inuse;
    logic [CW-1:0]               c_out_readers;

    // Keys live in one RAM, the writer/reader count pair in another. Both are read
    // through the registered port and only trusted when the valid flag says so.
    rwlt_ram #(
        .WIDTH (rwlt_pkg::KEY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_entry),
        .i_wdata (r_key),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (key_rd)
    );

    rwlt_ram #(
        .WIDTH (2 * CW),
        .DEPTH (TABLE_ENTRIES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (apply_we),
        .i_waddr (r_entry),
        .i_wdata (cnt_wr),
        .i_raddr (r_entry),
        .o_rdata (cnt_rd)
    );

    assign busy       = (r_state != rwlt_pkg::S_IDLE);
    assign c_accept   = start && !busy;
    assign c_match    = r_pend && r_valid[r_pidx] && (key_rd == r_key);
    assign c_scan_end = !r_pend && (r_idx == SCAN_END);
    assign apply_we   = (r_state == rwlt_pkg::S_APPLY);
    // claim writes the key; a hit leaves the key as it is
    assign key_we     = apply_we && !r_hit;
    assign cnt_wr     = {new_wc, new_rc};

    // Next state: scan with the shared comparator, then fetch counts, then update; a full table goes back to idle.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rwlt_pkg::S_IDLE: begin
                if (c_accept && i_kind != rwlt_pkg::KIND_NOP) begin
                    n_state = rwlt_pkg::S_SCAN;
                end
            end
            rwlt_pkg::S_SCAN: begin
                if (c_match) begin
                    n_state = rwlt_pkg::S_FETCH;
                end else if (c_scan_end) begin
                    n_state = r_free_ok ? rwlt_pkg::S_FETCH : rwlt_pkg::S_IDLE;
                end
            end
            rwlt_pkg::S_FETCH: n_state = rwlt_pkg::S_APPLY;
            rwlt_pkg::S_APPLY: n_state = rwlt_pkg::S_IDLE;
        endcase
    end

    // Update of the chosen entry. A freshly claimed entry starts from zero counts
    // and clear flags, whatever the RAM holds for it.
    always_comb begin
        cur_wc   = r_hit ? cnt_rd[2*CW-1:CW] : '0;
        cur_rc   = r_hit ? cnt_rd[CW-1:0]    : '0;
        cur_wh   = r_hit && r_wheld[r_entry];
        cur_rh   = r_hit && r_rheld[r_entry];
        new_wc   = cur_wc;
        new_rc   = cur_rc;
        new_wh   = cur_wh;
        new_rh   = cur_rh;
        c_status = rwlt_pkg::ST_DONE;
        unique case (r_kind)
            rwlt_pkg::KIND_READ: begin
                if (cur_wh) begin
                    c_status = rwlt_pkg::ST_BUSY;
                end else if (cur_rc == rwlt_pkg::COUNT_MAX) begin
                    c_status = rwlt_pkg::ST_RCFULL;
                end else begin
                    new_rc = cur_rc + CW'(1);
                    new_rh = 1'b1;
                end
            end
            rwlt_pkg::KIND_WRITE: begin
                if (cur_wh || cur_rh) begin
                    c_status = rwlt_pkg::ST_BUSY;
                end else begin
                    if (cur_wc != rwlt_pkg::COUNT_MAX) begin
                        new_wc = cur_wc + CW'(1);
                    end
                    new_wh = 1'b1;
                end
            end
            rwlt_pkg::KIND_UNLOCK: begin
                // drop the writer first; otherwise drop one reader
                if (cur_wh) begin
                    new_wh = 1'b0;
                    if (cur_wc != '0) begin
                        new_wc = cur_wc - CW'(1);
                    end
                end else if (cur_rh) begin
                    if (cur_rc != '0) begin
                        new_rc = cur_rc - CW'(1);
                    end
                    if (cur_rc <= CW'(1)) begin
                        new_rh = 1'b0;
                    end
                end
            end
            rwlt_pkg::KIND_NOP: begin
                c_status = rwlt_pkg::ST_DONE;
            end
        endcase
        c_used = (new_wc != '0) || (new_rc != '0);
    end

    // Result load: no-operation answer, table full answer, or the update answer.
    always_comb begin
        c_out_load    = 1'b0;
        c_out_status  = rwlt_pkg::ST_DONE;
        c_out_inuse   = 1'b0;
        c_out_readers = '0;
        unique case (r_state)
            rwlt_pkg::S_IDLE: begin
                c_out_load = c_accept && (i_kind == rwlt_pkg::KIND_NOP);
            end
            rwlt_pkg::S_SCAN: begin
                if (!c_match && c_scan_end && !r_free_ok) begin
                    c_out_load   = 1'b1;
                    c_out_status = rwlt_pkg::ST_FULL;
                end
            end
            rwlt_pkg::S_FETCH: begin
                c_out_load = 1'b0;
            end
            rwlt_pkg::S_APPLY: begin
                c_out_load    = 1'b1;
                c_out_status  = c_status;
                c_out_inuse   = (r_kind == rwlt_pkg::KIND_UNLOCK) && c_used;
                c_out_readers = new_rc;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rwlt_pkg::S_IDLE;
            r_valid  <= '0;
            r_wheld  <= '0;
            r_rheld  <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= c_out_load;
            if (apply_we) begin
                // free the entry when both counts reach zero
                r_valid[r_entry] <= c_used;
                r_wheld[r_entry] <= c_used && new_wh;
                r_rheld[r_entry] <= c_used && new_rh;
            end
        end
    end

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_kind    <= i_kind;
            r_key     <= i_key;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_state == rwlt_pkg::S_SCAN) begin
            // advance the read pointer; compare the entry read last cycle
            if (r_idx != SCAN_END) begin
                r_pend <= 1'b1;
                r_pidx <= r_idx[IDX_W-1:0];
                r_idx  <= r_idx + CNT_W'(1);
            end else begin
                r_pend <= 1'b0;
            end
            if (r_pend && !r_valid[r_pidx] && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_pidx;
            end
            if (c_match) begin
                r_entry <= r_pidx;
                r_hit   <= 1'b1;
            end else if (c_scan_end) begin
                r_entry <= r_free_idx;
                r_hit   <= 1'b0;
            end
        end
        if (c_out_load) begin
            o_status       <= c_out_status;
            o_still_in_use <= c_out_inuse;
            o_readers_now  <= c_out_readers;
        end
    end

    // The entry picked for the update is the hit if valid, a free one otherwise.
    a_fetch_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rwlt_pkg::S_FETCH) |-> (r_hit == r_valid[r_entry]))
        else $error("fetch entry does not agree with its valid flag");

    // After an update the entry stays valid exactly when it still has a holder.
    a_free_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rwlt_pkg::S_APPLY) |=> (r_valid[$past(r_entry)] == $past(c_used)))
        else $error("entry valid flag does not follow its counts");

    // Held flags only on valid entries.
    a_held_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_wheld | r_rheld) & ~r_valid) == '0)
        else $error("held flag on a free entry");

    // A no-operation request is answered done in the next cycle.
    a_nop_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_accept && i_kind == rwlt_pkg::KIND_NOP) |=>
            (o_strobe && o_status == rwlt_pkg::ST_DONE))
        else $error("no-operation request not answered");

endmodule
`default_nettype wire

### verif/tb_reader_writer_lock_table.sv
`timescale 1ns / 1ps
module tb_reader_writer_lock_table;
    import rwlt_pkg::*;

    localparam int NUM_SLOTS   = TABLE_ENTRIES_DEF;
    localparam int KEY_POOL_SZ = 20;
    localparam int RANDOM_REQS = 680;
    localparam int CALM_REQS   = 100;          // tail of the random part with no idling
    localparam int CYCLE_LIMIT = 300_000;
    localparam int DRAIN_WAIT  = NUM_SLOTS + 8;

    // One answer of the lock table: what the block strobes per item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                in_use;
        logic [COUNT_W-1:0]  readers;
    } t_lock_answer;

    // Shadow of the lock table plus the queue of answers still owed by the block.
    class t_lock_table_scoreboard;
        bit                 slot_valid [NUM_SLOTS];
        logic [KEY_W-1:0]   slot_key   [NUM_SLOTS];
        bit                 slot_wheld [NUM_SLOTS];
        bit                 slot_rheld [NUM_SLOTS];
        logic [COUNT_W-1:0] slot_wcnt  [NUM_SLOTS];
        logic [COUNT_W-1:0] slot_rcnt  [NUM_SLOTS];
        t_lock_answer       owed_answers[$];
        int                 mismatches;
        int                 kind_seen   [4];
        int                 status_seen [4];

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_valid[i] = 0;
                slot_key[i]   = '0;
                slot_wheld[i] = 0;
                slot_rheld[i] = 0;
                slot_wcnt[i]  = '0;
                slot_rcnt[i]  = '0;
            end
            mismatches = 0;
            for (int i = 0; i < 4; i++) begin
                kind_seen[i]   = 0;
                status_seen[i] = 0;
            end
        endfunction

        function int pending();
            return owed_answers.size();
        endfunction

        // Pick the key of a random live entry; found is 0 when the table is empty.
        function logic [KEY_W-1:0] held_key(output bit found);
            int live[$];
            for (int i = 0; i < NUM_SLOTS; i++)
                if (slot_valid[i])
                    live.push_back(i);
            found = (live.size() != 0);
            if (!found)
                return '0;
            return slot_key[live[$urandom_range(0, live.size() - 1)]];
        endfunction

        // Apply one accepted request to the shadow table and queue its answer.
        function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
            int           hit;
            int           free_slot;
            t_lock_answer ans;
            ans = '{status: ST_DONE, in_use: 1'b0, readers: '0};
            kind_seen[kind]++;
            if (kind != KIND_NOP) begin
                hit       = -1;
                free_slot = -1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_valid[i]) begin
                        if (hit < 0 && slot_key[i] == key)
                            hit = i;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit < 0 && free_slot >= 0) begin
                    hit              = free_slot;
                    slot_valid[hit]  = 1;
                    slot_key[hit]    = key;
                    slot_wheld[hit]  = 0;
                    slot_rheld[hit]  = 0;
                    slot_wcnt[hit]   = '0;
                    slot_rcnt[hit]   = '0;
                end
                if (hit < 0) begin
                    ans.status = ST_FULL;
                end else begin
                    case (kind)
                        KIND_READ: begin
                            if (slot_wheld[hit])
                                ans.status = ST_BUSY;
                            else if (slot_rcnt[hit] >= COUNT_MAX)
                                ans.status = ST_RCFULL;
                            else begin
                                slot_rcnt[hit]  = slot_rcnt[hit] + 1'b1;
                                slot_rheld[hit] = 1;
                            end
                        end
                        KIND_WRITE: begin
                            if (slot_wheld[hit] || slot_rheld[hit])
                                ans.status = ST_BUSY;
                            else begin
                                if (slot_wcnt[hit] < COUNT_MAX)
                                    slot_wcnt[hit] = slot_wcnt[hit] + 1'b1;
                                slot_wheld[hit] = 1;
                            end
                        end
                        default: begin
                            if (slot_wheld[hit]) begin
                                slot_wheld[hit] = 0;
                                if (slot_wcnt[hit] != 0)
                                    slot_wcnt[hit] = slot_wcnt[hit] - 1'b1;
                            end else if (slot_rheld[hit]) begin
                                if (slot_rcnt[hit] != 0)
                                    slot_rcnt[hit] = slot_rcnt[hit] - 1'b1;
                                if (slot_rcnt[hit] == 0)
                                    slot_rheld[hit] = 0;
                            end
                            ans.in_use = (slot_wcnt[hit] != 0 || slot_rcnt[hit] != 0);
                        end
                    endcase
                    ans.readers = slot_rcnt[hit];
                    if (slot_wcnt[hit] == 0 && slot_rcnt[hit] == 0) begin
                        slot_valid[hit] = 0;
                        slot_wheld[hit] = 0;
                        slot_rheld[hit] = 0;
                    end
                end
            end
            owed_answers.push_back(ans);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: MISMATCH %s", $time, what);
        endfunction

        // Compare one strobed answer with the oldest one owed.
        function void check_answer(logic [STATUS_W-1:0] status, logic in_use,
                                   logic [COUNT_W-1:0] readers);
            t_lock_answer want;
            if (status !== 'x)
                status_seen[status]++;
            if (owed_answers.size() == 0) begin
                flag($sformatf("unexpected answer status=%0d in_use=%0d readers=%0d",
                               status, in_use, readers));
                return;
            end
            want = owed_answers.pop_front();
            if (want.status !== status || want.in_use !== in_use ||
                want.readers !== readers)
                flag($sformatf({"status exp %0d got %0d, in_use exp %0d got %0d, ",
                                "readers exp %0d got %0d"},
                               want.status, status, want.in_use, in_use,
                               want.readers, readers));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    logic [KIND_W-1:0]   i_kind  = KIND_READ;
    logic [KEY_W-1:0]    i_key   = '0;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic                o_still_in_use;
    logic [COUNT_W-1:0]  o_readers_now;

    t_lock_table_scoreboard sb = new();
    bit                   idle_enable = 1'b1;
    logic [KEY_W-1:0]     key_pool [KEY_POOL_SZ];
    int                   cycle_count = 0;

    reader_writer_lock_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_key          (i_key),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_still_in_use (o_still_in_use),
        .o_readers_now  (o_readers_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sample answers at the edge that ends the strobe cycle; the block cannot be stalled.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            sb.check_answer(o_status, o_still_in_use, o_readers_now);
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one item and hold it until the block takes it. Leave start high when no
    // idle burst follows, so the next item goes out back to back.
    task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
        start  <= 1'b1;
        i_kind <= kind;
        i_key  <= key;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        sb.note_request(kind, key);
        if (idle_enable && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Draw one request: mostly lock/unlock pairs on a small key pool so that locks
    // stack up, collide and fill the table, with some stray keys and no-ops mixed in.
    task automatic random_request();
        int               pick;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        bit               found;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            kind = KIND_READ;
        else if (pick < 55)
            kind = KIND_WRITE;
        else if (pick < 94)
            kind = KIND_UNLOCK;
        else
            kind = KIND_NOP;
        if ($urandom_range(0, 99) < 88)
            key = key_pool[$urandom_range(0, KEY_POOL_SZ - 1)];
        else
            key = {$urandom, $urandom};
        // Steer most unlocks at a key that really is held.
        if (kind == KIND_UNLOCK && $urandom_range(0, 99) < 75) begin
            key = sb.held_key(found);
            if (!found)
                key = key_pool[$urandom_range(0, KEY_POOL_SZ - 1)];
        end
        issue_request(kind, key);
    endtask

    initial begin
        for (int i = 0; i < KEY_POOL_SZ; i++)
            key_pool[i] = {$urandom, $urandom};

        // Hold reset low from the start, then release it once.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Stack readers on key zero, refuse a writer, then drain it back to free.
        issue_request(KIND_READ, '0);
        issue_request(KIND_READ, '0);
        issue_request(KIND_WRITE, '0);
        issue_request(KIND_UNLOCK, '0);
        issue_request(KIND_UNLOCK, '0);
        // Write-hold the all-ones key: both a reader and a second writer bounce.
        issue_request(KIND_WRITE, '1);
        issue_request(KIND_READ, '1);
        issue_request(KIND_WRITE, '1);
        issue_request(KIND_UNLOCK, '1);
        // Unlock a key nobody holds, and a no-op.
        issue_request(KIND_UNLOCK, 64'h5555_5555_5555_5555);
        issue_request(KIND_NOP, 64'hAAAA_AAAA_AAAA_AAAA);

        // Fill every entry with a writer, then knock on a new key while full.
        for (int i = 0; i < NUM_SLOTS; i++)
            issue_request(KIND_WRITE, key_pool[i]);
        issue_request(KIND_READ, key_pool[NUM_SLOTS]);
        issue_request(KIND_UNLOCK, key_pool[NUM_SLOTS]);
        issue_request(KIND_NOP, key_pool[NUM_SLOTS]);

        // Random traffic; drop idling for the closing stretch.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS - CALM_REQS)
                idle_enable = 1'b0;
            random_request();
        end
        start <= 1'b0;

        // Drain owed answers, then watch a little longer for stray strobes.
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Requests: %0d read, %0d write, %0d unlock, %0d no-op",
                 sb.kind_seen[KIND_READ], sb.kind_seen[KIND_WRITE],
                 sb.kind_seen[KIND_UNLOCK], sb.kind_seen[KIND_NOP]);
        $display("Answers: %0d done, %0d busy, %0d table full, %0d reader limit; %0d mismatches",
                 sb.status_seen[ST_DONE], sb.status_seen[ST_BUSY],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_RCFULL], sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
